>>> design/slr_pkg.sv
// slr_pkg: shared types and codes for the styled line rasterizer
// no dependencies; used by the rasterizer top level and its checker
`default_nettype none

package slr_pkg;

  // line style register
  typedef logic [1:0] style_t;

  localparam style_t STYLE_DASHED = 2'd0;
  localparam style_t STYLE_DOTTED = 2'd1;
  localparam style_t STYLE_CENTER = 2'd2;

  // request kind
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // pattern thresholds on the step index
  localparam logic [3:0] DASH_LAST_ON   = 4'd8;
  localparam logic [3:0] CENTER_LAST_ON = 4'd4;
  localparam logic [2:0] CENTER_DOT     = 3'd2;
  localparam logic [2:0] DOT_ON         = 3'd0;

endpackage

`default_nettype wire

>>> design/slr_in_if.sv
// slr_in_if: request channel of the styled line rasterizer
// valid/ready handshake with start/step kind and two endpoints; no dependencies
`default_nettype none

interface slr_in_if #(
  parameter int COORD_BITS = 11
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] x_from;
  logic signed [COORD_BITS-1:0] y_from;
  logic signed [COORD_BITS-1:0] x_to;
  logic signed [COORD_BITS-1:0] y_to;

  modport source (output valid, kind, x_from, y_from, x_to, y_to, input ready);
  modport sink   (input valid, kind, x_from, y_from, x_to, y_to, output ready);
endinterface

`default_nettype wire

>>> design/slr_out_if.sv
// slr_out_if: pixel result channel of the styled line rasterizer
// valid/ready handshake with pixel coordinates and flags; no dependencies
`default_nettype none

interface slr_out_if #(
  parameter int COORD_BITS = 11
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         plot;
  logic                         valid_res;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, plot, valid_res, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, plot, valid_res, last, output ready);
endinterface

`default_nettype wire

>>> design/styled_line_rasterizer.sv
// styled_line_rasterizer: Bresenham line walker with a dash pattern
// depends on slr_pkg, slr_in_if and slr_out_if
//
// usage:
//   in_chan carries requests. a start request (kind = start) loads both
//   endpoints and returns the start pixel, always plotted. each step request
//   returns the next pixel along the major axis, with plot taken from the
//   style register and the step count, and last set on the endpoint.
//   a step with no line in progress returns valid_res = 0 and zero fields.
//   out_chan carries one result per request, in request order.
//   cfg_we / cfg_wdata write the line style (dashed, dotted, center); the
//   style is sampled at every step, so write it only while the block is idle.
// timing:
//   a request's result is registered and offered in the cycle after it is
//   taken. throughput is one request per cycle while out_chan is not stalled;
//   the line state update and the result both come from one short combinational
//   pass (delta abs and compare on start, one error add and coordinate increment on step).
//   a single output register parts the two sides: in_chan.ready is high
//   whenever that register is empty or being drained by out_chan.ready.
// reset:
//   synchronous active-low rst_n clears the style to dashed, drops any line
//   in progress and empties the output register.
// stall:
//   while out_chan.valid is high and out_chan.ready low, the result holds and
//   no request is taken.
`default_nettype none

module styled_line_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire slr_pkg::style_t cfg_wdata,
  slr_in_if.sink               in_chan,
  slr_out_if.source            out_chan
);
  import slr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 3;  // error term needs two growth bits plus sign

  // configuration
  style_t style_r;

  // line state
  logic [CB-1:0]        cur_x_r, cur_y_r;
  logic signed [EB-1:0] err_r;
  logic [CB-1:0]        maj_r, min_r;
  logic [CB-1:0]        idx_r, tot_r;
  logic [1:0]           dir_x_r, dir_y_r;  // two's complement -1, 0, +1
  logic                 swap_r;
  logic                 active_r;

  // output register
  logic                 out_valid_r;
  logic [CB-1:0]        out_x_r, out_y_r;
  logic                 out_plot_r, out_vres_r, out_last_r;

  logic accept;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // start path: deltas, directions, axis interchange
  logic signed [CB:0] dx, dy;
  logic [CB-1:0]      adx, ady;
  logic [1:0]         sdx, sdy;
  logic               st_swap;
  logic [CB-1:0]      st_maj, st_min;
  logic [EB-1:0]      st_err;

  always_comb begin
    dx      = $signed({in_chan.x_to[CB-1], in_chan.x_to})
            - $signed({in_chan.x_from[CB-1], in_chan.x_from});
    dy      = $signed({in_chan.y_to[CB-1], in_chan.y_to})
            - $signed({in_chan.y_from[CB-1], in_chan.y_from});
    // magnitude of a difference of two coordinates always fits in CB bits
    adx     = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady     = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    sdx     = (dx == '0) ? 2'b00 : (dx[CB] ? 2'b11 : 2'b01);
    sdy     = (dy == '0) ? 2'b00 : (dy[CB] ? 2'b11 : 2'b01);
    st_swap = ady > adx;
    st_maj  = st_swap ? ady : adx;
    st_min  = st_swap ? adx : ady;
    st_err  = {2'b00, st_min, 1'b0} - {3'b000, st_maj};
  end

  // step path: one Bresenham iteration
  logic          minor_move, x_move, y_move;
  logic [CB-1:0] step_dx, step_dy;
  logic [CB-1:0] sp_x, sp_y;
  logic [EB-1:0] sp_err;
  logic [CB-1:0] sp_idx;
  logic          sp_last;
  logic          sp_plot;

  always_comb begin
    minor_move = !err_r[EB-1];
    x_move     = swap_r ? minor_move : 1'b1;
    y_move     = swap_r ? 1'b1 : minor_move;
    step_dx    = {{(CB-2){dir_x_r[1]}}, dir_x_r};
    step_dy    = {{(CB-2){dir_y_r[1]}}, dir_y_r};
    sp_x       = cur_x_r + (x_move ? step_dx : '0);
    sp_y       = cur_y_r + (y_move ? step_dy : '0);
    sp_err     = err_r + {2'b00, min_r, 1'b0}
               - (minor_move ? {2'b00, maj_r, 1'b0} : {EB{1'b0}});
    sp_idx     = idx_r + 1'b1;
    sp_last    = sp_idx >= tot_r;
    // pattern phase from the new step count; style read every step
    unique case (style_r)
      STYLE_DASHED: sp_plot = sp_idx[3:0] <= DASH_LAST_ON;
      STYLE_DOTTED: sp_plot = sp_idx[2:0] == DOT_ON;
      STYLE_CENTER: sp_plot = (sp_idx[3:0] <= CENTER_LAST_ON)
                           || (sp_idx[2:0] == CENTER_DOT);
      default:      sp_plot = 1'b0;  // unused style code draws no step pixels
    endcase
  end

  // result selection
  logic [CB-1:0] res_x, res_y;
  logic          res_plot, res_vres, res_last;

  always_comb begin
    res_x    = '0;
    res_y    = '0;
    res_plot = 1'b0;
    res_vres = 1'b0;
    res_last = 1'b0;
    if (in_chan.kind == KIND_START) begin
      res_x    = in_chan.x_from;
      res_y    = in_chan.y_from;
      res_plot = 1'b1;
      res_vres = 1'b1;
      res_last = (st_maj == '0);  // zero-length line ends at once
    end else if (active_r) begin
      res_x    = sp_x;
      res_y    = sp_y;
      res_plot = sp_plot;
      res_vres = 1'b1;
      res_last = sp_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r     <= STYLE_DASHED;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        style_r <= cfg_wdata;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
        if (in_chan.kind == KIND_START) begin
          active_r <= (st_maj != '0);
        end else if (active_r && sp_last) begin
          active_r <= 1'b0;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line state and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_plot_r <= res_plot;
      out_vres_r <= res_vres;
      out_last_r <= res_last;
      if (in_chan.kind == KIND_START) begin
        cur_x_r <= in_chan.x_from;
        cur_y_r <= in_chan.y_from;
        err_r   <= st_err;
        maj_r   <= st_maj;
        min_r   <= st_min;
        idx_r   <= '0;
        tot_r   <= st_maj;
        dir_x_r <= sdx;
        dir_y_r <= sdy;
        swap_r  <= st_swap;
      end else if (active_r) begin
        cur_x_r <= sp_x;
        cur_y_r <= sp_y;
        err_r   <= sp_err;
        idx_r   <= sp_idx;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel_x   = out_x_r;
  assign out_chan.pixel_y   = out_y_r;
  assign out_chan.plot      = out_plot_r;
  assign out_chan.valid_res = out_vres_r;
  assign out_chan.last      = out_last_r;

endmodule

`default_nettype wire

>>> design/slr_checker.sv
// slr_checker: port-level assertions for the styled line rasterizer
// depends on slr_pkg; bound to styled_line_rasterizer below
`default_nettype none

module slr_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire in_kind,
  input wire out_valid,
  input wire out_ready,
  input wire out_plot,
  input wire out_valid_res,
  input wire out_last
);
  import slr_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an empty output register never blocks requests
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  // every accepted request shows a result next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("missing result after request");

  // start point is always a real, plotted pixel
  a_start_plot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_START |=> out_valid_res && out_plot)
    else $error("start pixel not plotted");

  // a line end only comes from a line in progress
  a_last_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_valid_res)
    else $error("last flag on an idle step");

endmodule

bind styled_line_rasterizer slr_checker u_slr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_kind       (in_chan.kind),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_plot      (out_chan.plot),
  .out_valid_res (out_chan.valid_res),
  .out_last      (out_chan.last)
);

`default_nettype wire
